@@ rtl/core/iprp_pkg.sv @@
// ----------------------------------------------------------------------------
// iprp_pkg
// Shared types, widths and helpers for the IPv4 range-to-prefix core.
// ----------------------------------------------------------------------------
package iprp_pkg;

  localparam int unsigned AddrW = 32;           // active address bits, 8..32
  localparam int unsigned PortW = 32;           // address port width
  localparam int unsigned PlenW = 6;            // prefix length port width
  localparam int unsigned SizeW = AddrW + 1;    // block size, up to 2^AddrW
  localparam int unsigned SumW  = AddrW + 2;    // headroom for cur + size - 1
  localparam int unsigned KW    = $clog2(AddrW + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ASC,
    ST_DESC
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // accept a new word
    logic asc_step;    // growing phase: try block at lowest set bit of cur
    logic desc_step;   // shrinking phase: try block of held size, then halve
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fits;        // candidate block stays at or below the end address
    logic hit_end;     // candidate block ends exactly at the end address
    logic range_bad;   // start above end on the input ports
  } status_t;

  // bit index of a one-hot block size
  function automatic logic [KW-1:0] onehot_index(input logic [SizeW-1:0] oh);
    logic [KW-1:0] r;
    r = '0;
    for (int i = 0; i < SizeW; i++) begin
      if (oh[i]) begin
        r = r | KW'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/iprp_ctrl.sv @@
// ----------------------------------------------------------------------------
// iprp_ctrl
// Sequencer: growing phase, then shrinking phase if a grown block overshoots, until the end is covered.
// ----------------------------------------------------------------------------
module iprp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  iprp_pkg::status_t  status_i,
  output iprp_pkg::cmd_t     cmd_o,
  output logic               busy_o
);

  iprp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iprp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iprp_pkg::ST_IDLE: begin
        if (start_i && !status_i.range_bad) begin
          state_d = iprp_pkg::ST_ASC;
        end
      end
      iprp_pkg::ST_ASC: begin
        if (!status_i.fits) begin
          state_d = iprp_pkg::ST_DESC;
        end else if (status_i.hit_end) begin
          state_d = iprp_pkg::ST_IDLE;
        end
      end
      iprp_pkg::ST_DESC: begin
        if (status_i.fits && status_i.hit_end) begin
          state_d = iprp_pkg::ST_IDLE;
        end
      end
      default: state_d = iprp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      iprp_pkg::ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.load  = start_i;
      end
      iprp_pkg::ST_ASC:  cmd_o.asc_step  = 1'b1;
      iprp_pkg::ST_DESC: cmd_o.desc_step = 1'b1;
      default:           busy_o = 1'b0;
    endcase
  end

  // a failed fit in the growing phase always hands over to the shrinking phase
  a_asc_to_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iprp_pkg::ST_ASC && !status_i.fits) |=> (state_q == iprp_pkg::ST_DESC))
    else $error("growing phase did not hand over");

endmodule

@@ rtl/core/iprp_dp.sv @@
// ----------------------------------------------------------------------------
// iprp_dp
// Address, end and size registers, fit check and registered result word.
// ----------------------------------------------------------------------------
module iprp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  iprp_pkg::cmd_t                    cmd_i,
  output iprp_pkg::status_t                 status_o,
  input  logic [iprp_pkg::PortW-1:0]        start_address_i,
  input  logic [iprp_pkg::PortW-1:0]        end_address_i,
  output logic                              result_valid_o,
  output logic [iprp_pkg::PortW-1:0]        block_base_o,
  output logic [iprp_pkg::PlenW-1:0]        block_prefix_length_o,
  output logic                              range_error_o,
  output logic                              last_block_o
);

  logic [iprp_pkg::SizeW-1:0] cur_q, cur_d;
  logic [iprp_pkg::AddrW-1:0] end_q, end_d;
  logic [iprp_pkg::SizeW-1:0] size_q, size_d;
  logic [iprp_pkg::KW-1:0]    k_q, k_d;

  logic                       vld_q, vld_d;
  logic [iprp_pkg::PortW-1:0] base_q, base_d;
  logic [iprp_pkg::PlenW-1:0] plen_q, plen_d;
  logic                       err_q, err_d, last_q, last_d;

  logic [iprp_pkg::AddrW-1:0] s_in, e_in;
  logic [iprp_pkg::SizeW-1:0] lowbit, size_sel;
  logic [iprp_pkg::KW-1:0]    k_sel;
  logic [iprp_pkg::SumW-1:0]  blk_top;
  logic                       fits, hit_end, emit;

  assign s_in = start_address_i[iprp_pkg::AddrW-1:0];
  assign e_in = end_address_i[iprp_pkg::AddrW-1:0];

  // largest aligned block at cur; zero is aligned to the whole space
  always_comb begin
    if (cur_q == '0) begin
      lowbit = iprp_pkg::SizeW'(1) << iprp_pkg::AddrW;
    end else begin
      lowbit = cur_q & (~cur_q + iprp_pkg::SizeW'(1));
    end
  end

  assign size_sel = cmd_i.asc_step ? lowbit : size_q;
  assign k_sel    = cmd_i.asc_step ? iprp_pkg::onehot_index(lowbit) : k_q;
  assign blk_top  = iprp_pkg::SumW'(cur_q) + iprp_pkg::SumW'(size_sel)
                  - iprp_pkg::SumW'(1);
  assign fits     = (blk_top <= iprp_pkg::SumW'(end_q));
  assign hit_end  = (blk_top == iprp_pkg::SumW'(end_q));
  assign emit     = (cmd_i.asc_step || cmd_i.desc_step) && fits;

  assign status_o.fits      = fits;
  assign status_o.hit_end   = hit_end;
  assign status_o.range_bad = (s_in > e_in);

  always_comb begin
    cur_d  = cur_q;
    end_d  = end_q;
    size_d = size_q;
    k_d    = k_q;
    vld_d  = 1'b0;
    base_d = base_q;
    plen_d = plen_q;
    err_d  = err_q;
    last_d = last_q;

    if (cmd_i.load) begin
      cur_d = iprp_pkg::SizeW'(s_in);
      end_d = e_in;
      if (s_in > e_in) begin
        vld_d  = 1'b1;
        base_d = '0;
        plen_d = '0;
        err_d  = 1'b1;
        last_d = 1'b1;
      end
    end

    if (emit) begin
      vld_d  = 1'b1;
      base_d = iprp_pkg::PortW'(cur_q[iprp_pkg::AddrW-1:0]);
      plen_d = iprp_pkg::PlenW'(iprp_pkg::AddrW) - iprp_pkg::PlenW'(k_sel);
      err_d  = 1'b0;
      last_d = hit_end;
      cur_d  = cur_q + size_sel;
    end

    // shrink after a failed grow, and after every shrinking-phase try
    if ((cmd_i.asc_step && !fits) || cmd_i.desc_step) begin
      size_d = size_sel >> 1;
      k_d    = k_sel - iprp_pkg::KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    end_q  <= end_d;
    size_q <= size_d;
    k_q    <= k_d;
    base_q <= base_d;
    plen_q <= plen_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  assign result_valid_o        = vld_q;
  assign block_base_o          = base_q;
  assign block_prefix_length_o = plen_q;
  assign range_error_o         = err_q;
  assign last_block_o          = last_q;

  a_size_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.desc_step |-> $onehot(size_q))
    else $error("shrinking block size not one-hot");

  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.asc_step || cmd_i.desc_step) |->
      (iprp_pkg::SumW'(cur_q) <= iprp_pkg::SumW'(end_q)))
    else $error("walk passed the end address");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && err_q) |-> (last_q && base_q == '0 && plen_q == '0))
    else $error("error word malformed");

endmodule

@@ rtl/core/ipv4_range_to_prefixes_core.sv @@
// ----------------------------------------------------------------------------
// ipv4_range_to_prefixes_core
// Splits an inclusive IPv4 range into its minimal ascending CIDR block list.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start_address_i / end_address_i and pulse start_i while busy_o is
//   low; the word is taken at that clock edge. Results come out on
//   block_base_o / block_prefix_length_o, each marked by a single cycle of
//   result_valid_o; last_block_o flags the final block of a range.
//   Start above end gives one word with range_error_o and last_block_o set
//   in the cycle after start, and busy_o never rises.
// Operation:
//   Start is registered in the sequencer state, and the first block then in
//   the result register. The walk first grows blocks at the lowest set bit
//   of the running address (one block per cycle); once a grown block would
//   pass the end, it turns around and shrinks the block size by half each
//   cycle, emitting whenever the halved block still fits. A range yields at
//   most 62 blocks. busy_o drops as the last block is issued, so a new range
//   may start the cycle that last block is on the ports.
// Reset: asynchronous, active low; returns the sequencer to idle and drops
//   result_valid_o. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module ipv4_range_to_prefixes_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [iprp_pkg::PortW-1:0]        start_address_i,
  input  logic [iprp_pkg::PortW-1:0]        end_address_i,
  output logic                              result_valid_o,
  output logic [iprp_pkg::PortW-1:0]        block_base_o,
  output logic [iprp_pkg::PlenW-1:0]        block_prefix_length_o,
  output logic                              range_error_o,
  output logic                              last_block_o
);

  iprp_pkg::cmd_t    cmd;
  iprp_pkg::status_t status;

  // sequencer
  iprp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // address walk and result register
  iprp_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .start_address_i       (start_address_i),
    .end_address_i         (end_address_i),
    .result_valid_o        (result_valid_o),
    .block_base_o          (block_base_o),
    .block_prefix_length_o (block_prefix_length_o),
    .range_error_o         (range_error_o),
    .last_block_o          (last_block_o)
  );

endmodule

@@ sim/tb_ipv4_range_to_prefixes_core.sv @@
// ----------------------------------------------------------------------------
// tb_ipv4_range_to_prefixes_core
// Self-checking bench: inclusive IPv4 ranges in, CIDR block words checked out.
// ----------------------------------------------------------------------------
// A directed set covers the corners: single addresses, the whole space,
// start above end, the longest covers and aligned blocks. A random set follows
// with ranges of every span size. The start side pauses in random bursts, and
// the last stretch has no pauses. Every accepted range is expanded on the
// spot into the greedy ascending block list. Each result word is checked
// against the oldest block still pending.
// ----------------------------------------------------------------------------
module tb_ipv4_range_to_prefixes_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AW        = iprp_pkg::AddrW;
  localparam int unsigned PW        = iprp_pkg::PortW;
  localparam int unsigned LW        = iprp_pkg::PlenW;
  localparam int          MaxBlocks = 62;    // hard cap on words per range
  localparam int          RandCount = 310;
  localparam int          CalmTail  = 60;    // last random ranges go back to back
  localparam int          Settle    = 80;    // cycles allowed after the last word
  localparam int          DirCount  = 20;

  // one result word as seen on the ports
  typedef struct packed {
    logic [PW-1:0] base;
    logic [LW-1:0] plen;
    logic          err;
    logic          last;
  } cidr_word_t;

  // Expands every accepted range into its block list and checks result words
  // against that list in order.
  class cidr_tracker;
    cidr_word_t pending_blocks[$];
    int         fail_count;

    function new();
      fail_count = 0;
    endfunction

    function int pending();
      return pending_blocks.size();
    endfunction

    // greedy cover: largest aligned power-of-two block that stays within the end
    function void note_range(logic [PW-1:0] start_addr, logic [PW-1:0] end_addr);
      logic [63:0] mask;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] cur;
      logic [63:0] span;
      int          k;
      int          n;
      cidr_word_t  w;
      mask = (64'd1 << AW) - 64'd1;
      lo   = {32'd0, start_addr} & mask;
      hi   = {32'd0, end_addr} & mask;
      if (lo > hi) begin
        w = '{base: '0, plen: '0, err: 1'b1, last: 1'b1};
        pending_blocks.push_back(w);
        return;
      end
      cur = lo;
      n   = 0;
      while (cur <= hi && n < MaxBlocks) begin
        k = 0;
        while (k < AW) begin
          span = 64'd1 << (k + 1);
          if ((cur & (span - 64'd1)) != 64'd0) break;
          if (cur + span - 64'd1 > hi) break;
          k++;
        end
        w = '{base: cur[PW-1:0], plen: LW'(AW - k), err: 1'b0, last: 1'b0};
        pending_blocks.push_back(w);
        n++;
        cur = cur + (64'd1 << k);
      end
      pending_blocks[pending_blocks.size() - 1].last = 1'b1;
    endfunction

    function void check_word(cidr_word_t got);
      cidr_word_t want;
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected word base=%h plen=%0d err=%b last=%b",
                 $time, got.base, got.plen, got.err, got.last);
        fail_count++;
        return;
      end
      want = pending_blocks.pop_front();
      if (got.base !== want.base) begin
        $display("%0t: block_base expected %h actual %h", $time, want.base, got.base);
        fail_count++;
      end
      if (got.plen !== want.plen) begin
        $display("%0t: block_prefix_length expected %0d actual %0d (base %h)",
                 $time, want.plen, got.plen, want.base);
        fail_count++;
      end
      if (got.err !== want.err) begin
        $display("%0t: range_error expected %b actual %b", $time, want.err, got.err);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last_block expected %b actual %b (base %h)",
                 $time, want.last, got.last, want.base);
        fail_count++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  logic [PW-1:0] start_address_i;
  logic [PW-1:0] end_address_i;
  logic          result_valid_o;
  logic [PW-1:0] block_base_o;
  logic [LW-1:0] block_prefix_length_o;
  logic          range_error_o;
  logic          last_block_o;

  cidr_tracker tracker = new();

  // corner ranges, paired by index
  localparam logic [PW-1:0] DirLo [DirCount] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 32'h0A00_0000, 32'h8000_0000,
    32'h0000_0000, 32'hC0A8_0001, 32'h1234_5679, 32'h0000_0005, 32'h5555_5555,
    32'h0000_0001, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFE
  };
  localparam logic [PW-1:0] DirHi [DirCount] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
    32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0AFF_FFFF, 32'hFFFF_FFFF,
    32'h7FFF_FFFF, 32'hC0A8_00FE, 32'h1234_5678, 32'h0000_0006, 32'hAAAA_AAAA,
    32'h0000_0001, 32'h8000_0000, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFF
  };

  ipv4_range_to_prefixes_core u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start_i               (start_i),
    .busy_o                (busy_o),
    .start_address_i       (start_address_i),
    .end_address_i         (end_address_i),
    .result_valid_o        (result_valid_o),
    .block_base_o          (block_base_o),
    .block_prefix_length_o (block_prefix_length_o),
    .range_error_o         (range_error_o),
    .last_block_o          (last_block_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver cannot stall, so every strobed word is taken at the edge
  // that ends its cycle. Values read here are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      tracker.check_word('{base: block_base_o, plen: block_prefix_length_o,
                           err: range_error_o, last: last_block_o});
    end
  end

  // Hold the word on the ports with start high until an edge sees busy low.
  // Start stays high on return so a back-to-back word needs no re-raise.
  task automatic send_range(input logic [PW-1:0] lo, input logic [PW-1:0] hi);
    start_i         <= 1'b1;
    start_address_i <= lo;
    end_address_i   <= hi;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    tracker.note_range(lo, hi);
  endtask

  task automatic pause_start(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // sender holds off until every pending block has come out
  task automatic drain_blocks();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Random range: mostly valid ranges of a random span class, some fully
  // random pairs (about half come out reversed), some reversed on purpose
  // and some pinned to a single address or to the top of the space.
  task automatic pick_range(output logic [PW-1:0] lo, output logic [PW-1:0] hi);
    logic [63:0] span_mask;
    logic [63:0] sum;
    logic [63:0] step;
    int          kind;
    int          align;
    kind      = $urandom_range(0, 9);
    span_mask = (64'd1 << $urandom_range(0, 32)) - 64'd1;
    lo        = $urandom;
    if (kind <= 5) begin
      // aligned starts let the cover open with a large block
      if ($urandom_range(0, 2) == 0) begin
        align = $urandom_range(1, 31);
        lo    = lo & ~((32'd1 << align) - 32'd1);
      end
      sum = {32'd0, lo} + ({32'd0, $urandom} & span_mask);
      hi  = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[PW-1:0];
    end else if (kind <= 7) begin
      hi = $urandom;
    end else if (kind == 8) begin
      // start above end by at least one
      if (lo == 32'd0) lo = 32'd1;
      step = 64'd1 + ({32'd0, $urandom} & span_mask);
      hi   = (step > {32'd0, lo}) ? 32'd0 : lo - step[PW-1:0];
    end else begin
      hi = ($urandom_range(0, 1) == 0) ? lo : 32'hFFFF_FFFF;
    end
  endtask

  initial begin
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    int            gap_odds;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    start_address_i = '0;
    end_address_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners first, with the odd pause so starts land mid-walk
    for (int i = 0; i < DirCount; i++) begin
      send_range(DirLo[i], DirHi[i]);
      if ($urandom_range(0, 2) == 0) pause_start($urandom_range(1, 15));
    end
    drain_blocks();

    gap_odds = 0;
    for (int i = 0; i < RandCount; i++) begin
      // new pause density every 40 ranges; zero means a stretch of no pauses
      if (i % 40 == 0) gap_odds = $urandom_range(0, 3);
      pick_range(lo, hi);
      send_range(lo, hi);
      if (i == RandCount / 3 || i == (2 * RandCount) / 3) begin
        drain_blocks();
      end else if (i < RandCount - CalmTail && gap_odds != 0 &&
                   $urandom_range(0, 3) < gap_odds) begin
        pause_start($urandom_range(1, 15));
      end
    end

    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (tracker.fail_count == 0) begin
      $display("ipv4_range_to_prefixes_core: match");
    end else begin
      $display("ipv4_range_to_prefixes_core: mismatch");
    end
    $finish;
  end

  // about 330 ranges at up to 62 words plus the longest pause each stays
  // under 0.3 ms; this allows roughly ten times that
  initial begin
    #3ms;
    $display("%0t: timeout", $time);
    $display("ipv4_range_to_prefixes_core: mismatch");
    $finish;
  end

endmodule
